// ===== sv/lrupr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LRU page replacement core.
// No dependencies; used by lrupr_ctrl, lrupr_datapath and the top level.
package lrupr_pkg;

    localparam int PAGE_PORT_W  = 16;
    localparam int FRAME_IDX_W  = 3;
    localparam int COUNT_W      = 16;
    localparam int CFG_W        = 4;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(4);
    localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch request page, clear scan results
        logic issue;   // read frame at scan index, advance index
        logic commit;  // apply update, load result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_issue;  // scan index sits on the last active frame
        logic out_free;    // result register can take a new result
    } dp_stat_t;

endpackage

// ===== sv/lru_page_replacement_core.sv =====
`timescale 1ns / 1ps
// Top level of the LRU page replacement core: config register, sequencer, datapath.
// Depends on lrupr_pkg, lrupr_ctrl and lrupr_datapath.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | s_valid / s_ready  | s_page_number
//  result    | m_valid / m_ready  | m_hit, m_frame_index, m_evicted_valid,
//            |                    | m_evicted_page, m_fault_count
//  config    | cfg_we (no wait)   | cfg_wdata (frames_in_use)
//
// Scan: each request reads the active frames. The page store has one read
//   port and the scan reads one frame per cycle.
// Reset: valid bits and recency ranks clear at once (no clearing pass);
//   frames_in_use returns to 4, fault count to zero.
// Stalls: a finished result waits in the result register while the next request
//   is taken and scanned; commit holds only while that register is full and m_ready low.
module lru_page_replacement_core #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lrupr_pkg::PAGE_PORT_W-1:0]     s_page_number,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [lrupr_pkg::FRAME_IDX_W-1:0]     m_frame_index,
    output logic                                  m_evicted_valid,
    output logic [lrupr_pkg::PAGE_PORT_W-1:0]     m_evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]         m_fault_count
);

    localparam int IDX_W = $clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2);

    logic [lrupr_pkg::CFG_W-1:0] frames_in_use_reg;
    logic [IDX_W-1:0]            last_idx;
    lrupr_pkg::dp_cmd_t          cmd;
    lrupr_pkg::dp_stat_t         stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= lrupr_pkg::CFG_RESET;
        end else if (cfg_we) begin
            frames_in_use_reg <= cfg_wdata;
        end
    end

    // Last active frame: zero acts as one frame, too many clamps to all frames.
    always_comb begin
        if (frames_in_use_reg == '0) begin
            last_idx = '0;
        end else if (32'(frames_in_use_reg) >= MAX_FRAMES) begin
            last_idx = IDX_W'(MAX_FRAMES - 1);
        end else begin
            last_idx = IDX_W'(32'(frames_in_use_reg) - 32'd1);
        end
    end

    lrupr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lrupr_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .last_idx        (last_idx),
        .s_page_number   (s_page_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_frame_index   (m_frame_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_fault_count   (m_fault_count)
    );

    // one request in flight: after acceptance the scan must start
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && cmd.issue))
        else $error("request accepted while another is in flight");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> !m_evicted_valid)
        else $error("hit result reports an eviction");

    a_evict_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted_valid) |-> (m_evicted_page == '0))
        else $error("evicted page not zero without eviction");

    a_commit_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !cmd.issue && !s_ready)
        else $error("commit overlaps scan or idle");

endmodule

// ===== sv/lrupr_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for one request: accept, scan frames, drain read, commit.
// Depends on lrupr_pkg.
module lrupr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lrupr_pkg::dp_stat_t stat,
    output lrupr_pkg::dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.start  = (state_reg == ST_IDLE) && s_valid;
    assign cmd.issue  = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_COMMIT) && stat.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/lrupr_datapath.sv =====
`timescale 1ns / 1ps
// Frame store, recency ranks, scan accumulators, fault counter, result register.
// Depends on lrupr_pkg.
module lrupr_datapath #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lrupr_pkg::dp_cmd_t                    cmd,
    output lrupr_pkg::dp_stat_t                   stat,
    input  logic [$clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2)-1:0] last_idx,
    input  logic [lrupr_pkg::PAGE_PORT_W-1:0]     s_page_number,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [lrupr_pkg::FRAME_IDX_W-1:0]     m_frame_index,
    output logic                                  m_evicted_valid,
    output logic [lrupr_pkg::PAGE_PORT_W-1:0]     m_evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]         m_fault_count
);

    localparam int IDX_W = $clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2);
    localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(MAX_FRAMES - 1);

    // page store: one read port (scan), one write port (commit)
    logic [PAGE_BITS-1:0] page_mem [MAX_FRAMES];
    logic                 valid_reg [MAX_FRAMES];
    logic [IDX_W-1:0]     rank_reg  [MAX_FRAMES];

    logic [PAGE_BITS-1:0] page_reg;
    logic [IDX_W-1:0]     scan_idx_reg;

    // registered read stage
    logic [PAGE_BITS-1:0] rd_page_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     rd_rank_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_live_reg;

    // scan results
    logic                 found_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [IDX_W-1:0]     hit_rank_reg;
    logic                 empty_reg;
    logic [IDX_W-1:0]     empty_idx_reg;
    logic [IDX_W-1:0]     best_rank_reg;
    logic [IDX_W-1:0]     vict_idx_reg;
    logic [PAGE_BITS-1:0] vict_page_reg;

    logic [lrupr_pkg::COUNT_W-1:0] faults_reg;
    logic                          m_valid_reg;

    logic             evict;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] limit;
    logic             age_all;

    assign evict   = !found_reg && !empty_reg;
    assign slot    = found_reg ? hit_idx_reg : (empty_reg ? empty_idx_reg : vict_idx_reg);
    assign limit   = found_reg ? hit_rank_reg : best_rank_reg;
    assign age_all = !found_reg && empty_reg;

    assign stat.last_issue = (scan_idx_reg == last_idx);
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;

    // page store writes and scan read
    always_ff @(posedge aclk) begin
        if (cmd.commit && !found_reg) begin
            page_mem[slot] <= page_reg;
        end
        if (cmd.issue) begin
            rd_page_reg <= page_mem[scan_idx_reg];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            page_reg <= PAGE_BITS'(s_page_number);
        end
        if (cmd.issue) begin
            rd_valid_reg <= valid_reg[scan_idx_reg];
            rd_rank_reg  <= rank_reg[scan_idx_reg];
            rd_idx_reg   <= scan_idx_reg;
        end
        if (rd_live_reg) begin
            if (rd_valid_reg && (rd_page_reg == page_reg) && !found_reg) begin
                hit_idx_reg  <= rd_idx_reg;
                hit_rank_reg <= rd_rank_reg;
            end
            if (!rd_valid_reg && !empty_reg) begin
                empty_idx_reg <= rd_idx_reg;
            end
            // first frame with the largest rank
            if ((rd_idx_reg == '0) || (rd_rank_reg > best_rank_reg)) begin
                best_rank_reg <= rd_rank_reg;
                vict_idx_reg  <= rd_idx_reg;
                vict_page_reg <= rd_page_reg;
            end
        end
        if (cmd.commit) begin
            m_hit           <= found_reg;
            m_frame_index   <= lrupr_pkg::FRAME_IDX_W'(slot);
            m_evicted_valid <= evict;
            m_evicted_page  <= evict ? lrupr_pkg::PAGE_PORT_W'(vict_page_reg)
                                     : '0;
            m_fault_count   <= (!found_reg && (faults_reg != lrupr_pkg::COUNT_TOP))
                               ? faults_reg + 1'b1 : faults_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rd_live_reg  <= 1'b0;
            found_reg    <= 1'b0;
            empty_reg    <= 1'b0;
            faults_reg   <= '0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < MAX_FRAMES; k++) begin
                valid_reg[k] <= 1'b0;
                rank_reg[k]  <= '0;
            end
        end else begin
            rd_live_reg <= cmd.issue;
            if (cmd.start) begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
                empty_reg    <= 1'b0;
            end else if (cmd.issue) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (rd_live_reg) begin
                if (rd_valid_reg && (rd_page_reg == page_reg)) begin
                    found_reg <= 1'b1;
                end
                if (!rd_valid_reg) begin
                    empty_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                for (int k = 0; k < MAX_FRAMES; k++) begin
                    if (IDX_W'(k) == slot) begin
                        rank_reg[k] <= '0;
                    end else if ((IDX_W'(k) <= last_idx) && valid_reg[k]
                                 && (age_all || (rank_reg[k] < limit))
                                 && (rank_reg[k] != RANK_TOP)) begin
                        rank_reg[k] <= rank_reg[k] + 1'b1;
                    end
                end
                if (!found_reg) begin
                    valid_reg[slot] <= 1'b1;
                    if (faults_reg != lrupr_pkg::COUNT_TOP) begin
                        faults_reg <= faults_reg + 1'b1;
                    end
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== tb/lru_page_replacement_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement_core: directed table, random phases, rushed tail.
// Depends on lrupr_pkg and the core; predicts each result with its own LRU frame mirror.
module lru_page_replacement_core_tb;
    import lrupr_pkg::*;

    localparam int MAX_FRAMES   = 8;
    localparam int PAGE_BITS    = 16;
    localparam int RANK_TOP     = MAX_FRAMES - 1;
    localparam int DIR_ROWS     = 25;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 85;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int FLUSH_CYCLES = 30;
    localparam int RUSH_ITEMS   = 48;
    localparam int SHOW_LIMIT   = 10;

    // table row flags
    localparam bit CFG_KEEP     = 1'b0;
    localparam bit CFG_LOAD     = 1'b1;
    localparam bit BY_PREDICTOR = 1'b0;
    localparam bit BY_TABLE     = 1'b1;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame;
        logic                   ev_valid;
        logic [PAGE_PORT_W-1:0] ev_page;
        logic [COUNT_W-1:0]     faults;
    } page_result_t;

    localparam page_result_t NO_RESULT = '0;

    typedef struct {
        bit                     cfg_set;
        logic [CFG_W-1:0]       cfg_val;
        logic [PAGE_PORT_W-1:0] page;
        bit                     typed;
        page_result_t           want;
    } stim_row_t;

    typedef enum logic [1:0] {RCV_OPEN, RCV_COIN, RCV_TIGHT} rcv_style_t;

    logic                   aclk            = 1'b0;
    logic                   aresetn         = 1'b0;
    logic                   cfg_we          = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata       = '0;
    logic                   s_valid         = 1'b0;
    logic                   s_ready;
    logic [PAGE_PORT_W-1:0] s_page_number   = '0;
    logic                   m_valid;
    logic                   m_ready         = 1'b0;
    logic                   m_hit;
    logic [FRAME_IDX_W-1:0] m_frame_index;
    logic                   m_evicted_valid;
    logic [PAGE_PORT_W-1:0] m_evicted_page;
    logic [COUNT_W-1:0]     m_fault_count;

    lru_page_replacement_core #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_page_number   (s_page_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_frame_index   (m_frame_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_fault_count   (m_fault_count)
    );

    always #6 aclk = ~aclk;

    // Mirror of the frame table
    logic [PAGE_PORT_W-1:0] mir_page  [MAX_FRAMES];
    logic                   mir_valid [MAX_FRAMES];
    logic [2:0]             mir_rank  [MAX_FRAMES];
    logic [COUNT_W-1:0]     mir_faults = '0;
    logic [CFG_W-1:0]       mir_frames = CFG_RESET;

    page_result_t pending_results [$];
    stim_row_t    dir_rows [DIR_ROWS];
    logic [CFG_W-1:0] cfg_plan [RAND_PHASES] =
        '{4'd3, 4'd8, 4'd1, 4'd6, 4'd2, 4'd12, 4'd5, 4'd7, 4'd0, 4'd15};

    int  mismatches    = 0;
    int  requests_sent = 0;
    int  results_seen  = 0;
    int  hits_seen     = 0;
    int  evicts_seen   = 0;
    int  cfg_writes    = 0;
    int  burst_left    = 0;
    bit  valid_held    = 1'b0;
    bit  rush          = 1'b0;  // no idling on either side
    int  hold_requests = 0;

    // Age every active valid frame younger than limit, except skip
    function automatic void age_ranks(input int n, input int limit, input int skip);
        for (int k = 0; k < n; k++) begin
            if (k != skip && mir_valid[k] && int'(mir_rank[k]) < limit &&
                int'(mir_rank[k]) < RANK_TOP)
                mir_rank[k] = mir_rank[k] + 3'd1;
        end
    endfunction

    function automatic page_result_t lru_predict(input logic [PAGE_PORT_W-1:0] pg);
        page_result_t r;
        int n;
        int slot;
        int best;
        bit found;
        bit spare;
        r = NO_RESULT;
        slot = 0;
        found = 1'b0;
        spare = 1'b0;
        if (mir_frames == 0)
            n = 1;
        else if (int'(mir_frames) > MAX_FRAMES)
            n = MAX_FRAMES;
        else
            n = int'(mir_frames);
        // lowest matching frame wins
        for (int k = 0; k < n; k++) begin
            if (!found && mir_valid[k] && mir_page[k] == pg) begin
                slot = k;
                found = 1'b1;
            end
        end
        if (found) begin
            age_ranks(n, int'(mir_rank[slot]), slot);
        end else begin
            for (int k = 0; k < n; k++) begin
                if (!spare && !mir_valid[k]) begin
                    slot = k;
                    spare = 1'b1;
                end
            end
            if (spare) begin
                age_ranks(n, MAX_FRAMES + 1, slot);
            end else begin
                // oldest frame, lowest index on ties
                best = int'(mir_rank[0]);
                slot = 0;
                for (int k = 1; k < n; k++) begin
                    if (int'(mir_rank[k]) > best) begin
                        best = int'(mir_rank[k]);
                        slot = k;
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page  = mir_page[slot];
                age_ranks(n, best, slot);
            end
            mir_page[slot]  = pg;
            mir_valid[slot] = 1'b1;
            if (mir_faults != COUNT_TOP)
                mir_faults = mir_faults + 1'b1;
        end
        mir_rank[slot] = 3'd0;
        r.hit    = found;
        r.frame  = slot[FRAME_IDX_W-1:0];
        r.faults = mir_faults;
        return r;
    endfunction

    // Offer one request; valid stays up between back-to-back requests of a burst
    task automatic offer_page(input logic [PAGE_PORT_W-1:0] pg, input bit typed,
                              input page_result_t want);
        int gap;
        page_result_t predicted;
        if (!rush && burst_left <= 0) begin
            if (valid_held)
                s_valid <= 1'b0;
            valid_held = 1'b0;
            gap = $urandom_range(1, 20);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_page_number <= pg;
        valid_held = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = lru_predict(pg);
        pending_results.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    // Drop valid and wait until every pending request has its result
    task automatic wait_all_results();
        if (valid_held)
            s_valid <= 1'b0;
        valid_held = 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] v);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mir_frames = v;
        cfg_writes++;
    endtask

    task automatic report_mismatch(input string what, input page_result_t want,
                                   input page_result_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
            $display("%0t mismatch (%s): exp hit=%0d frame=%0d ev=%0d evp=%h fc=%0d",
                     $time, what, want.hit, want.frame, want.ev_valid, want.ev_page,
                     want.faults);
            $display("    got hit=%0d frame=%0d ev=%0d evp=%h fc=%0d",
                     got.hit, got.frame, got.ev_valid, got.ev_page, got.faults);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin : check_results
        page_result_t got;
        page_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_hit, m_frame_index, m_evicted_valid, m_evicted_page, m_fault_count};
            results_seen++;
            if (m_hit)
                hits_seen++;
            if (m_evicted_valid)
                evicts_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("no request pending", NO_RESULT, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_mismatch("field", want, got);
            end
        end
    end

    // Receiver: stretches of open, coin-flip and tight stalling, plus long hold-offs on demand
    int         holds_served = 0;
    int         hold_left    = 0;
    int         stretch_left = 0;
    rcv_style_t rcv_style    = RCV_OPEN;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (rush) begin
            m_ready <= 1'b1;
        end else begin
            if (stretch_left == 0) begin
                stretch_left <= $urandom_range(8, 120);
                rcv_style    <= rcv_style_t'($urandom_range(0, 2));
            end else begin
                stretch_left <= stretch_left - 1;
            end
            case (rcv_style)
                RCV_OPEN: begin
                    m_ready <= 1'b1;
                end
                RCV_COIN: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // Watchdog on cycles with no handshake on either channel
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d results pending",
                         idle_cycles, pending_results.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int ws_n;
        logic [PAGE_PORT_W-1:0] pg;
        logic [PAGE_PORT_W-1:0] work_set [12];

        for (int k = 0; k < MAX_FRAMES; k++) begin
            mir_page[k]  = '0;
            mir_valid[k] = 1'b0;
            mir_rank[k]  = 3'd0;
        end

        // Directed table: reset frame count first, then zero, above-max, shrink and regrow
        dir_rows[0]  = '{CFG_KEEP, 4'd0,  16'h0000, BY_TABLE, {1'b0, 3'd0, 1'b0, 16'h0000, 16'd1}};
        dir_rows[1]  = '{CFG_KEEP, 4'd0,  16'hFFFF, BY_TABLE, {1'b0, 3'd1, 1'b0, 16'h0000, 16'd2}};
        dir_rows[2]  = '{CFG_KEEP, 4'd0,  16'h0000, BY_TABLE, {1'b1, 3'd0, 1'b0, 16'h0000, 16'd2}};
        dir_rows[3]  = '{CFG_KEEP, 4'd0,  16'h1234, BY_TABLE, {1'b0, 3'd2, 1'b0, 16'h0000, 16'd3}};
        dir_rows[4]  = '{CFG_KEEP, 4'd0,  16'hAAAA, BY_TABLE, {1'b0, 3'd3, 1'b0, 16'h0000, 16'd4}};
        dir_rows[5]  = '{CFG_KEEP, 4'd0,  16'h5555, BY_PREDICTOR, NO_RESULT};  // full: evict LRU
        dir_rows[6]  = '{CFG_LOAD, 4'd0,  16'h0007, BY_PREDICTOR, NO_RESULT};  // zero acts as one
        dir_rows[7]  = '{CFG_KEEP, 4'd0,  16'h0008, BY_TABLE, {1'b0, 3'd0, 1'b1, 16'h0007, 16'd7}};
        dir_rows[8]  = '{CFG_KEEP, 4'd0,  16'h0008, BY_TABLE, {1'b1, 3'd0, 1'b0, 16'h0000, 16'd7}};
        dir_rows[9]  = '{CFG_LOAD, 4'd15, 16'h0100, BY_PREDICTOR, NO_RESULT};  // clamps to max
        dir_rows[10] = '{CFG_KEEP, 4'd0,  16'h0101, BY_PREDICTOR, NO_RESULT};
        dir_rows[11] = '{CFG_KEEP, 4'd0,  16'h0102, BY_PREDICTOR, NO_RESULT};
        dir_rows[12] = '{CFG_KEEP, 4'd0,  16'h0103, BY_PREDICTOR, NO_RESULT};
        dir_rows[13] = '{CFG_KEEP, 4'd0,  16'h5555, BY_PREDICTOR, NO_RESULT};
        dir_rows[14] = '{CFG_LOAD, 4'd2,  16'h0103, BY_PREDICTOR, NO_RESULT};  // resident but inactive
        dir_rows[15] = '{CFG_KEEP, 4'd0,  16'h0103, BY_PREDICTOR, NO_RESULT};
        dir_rows[16] = '{CFG_LOAD, 4'd8,  16'h0103, BY_PREDICTOR, NO_RESULT};  // two copies: lowest hits
        dir_rows[17] = '{CFG_KEEP, 4'd0,  16'h0200, BY_PREDICTOR, NO_RESULT};
        dir_rows[18] = '{CFG_KEEP, 4'd0,  16'h0000, BY_PREDICTOR, NO_RESULT};
        dir_rows[19] = '{CFG_LOAD, 4'd1,  16'h0300, BY_PREDICTOR, NO_RESULT};
        dir_rows[20] = '{CFG_KEEP, 4'd0,  16'h0301, BY_PREDICTOR, NO_RESULT};
        dir_rows[21] = '{CFG_KEEP, 4'd0,  16'h0302, BY_PREDICTOR, NO_RESULT};
        dir_rows[22] = '{CFG_LOAD, 4'd8,  16'h0400, BY_PREDICTOR, NO_RESULT};  // stale ranks tie
        dir_rows[23] = '{CFG_KEEP, 4'd0,  16'h0401, BY_PREDICTOR, NO_RESULT};
        dir_rows[24] = '{CFG_KEEP, 4'd0,  16'h0402, BY_PREDICTOR, NO_RESULT};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].cfg_set == CFG_LOAD)
                write_frames(dir_rows[i].cfg_val);
            offer_page(dir_rows[i].page, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases: a small working set per phase so hits and evictions mix
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RAND_PHASES - 1)
                write_frames(CFG_W'($urandom_range(0, 15)));
            else
                write_frames(cfg_plan[ph]);
            ws_n = $urandom_range(1, 12);
            for (int w = 0; w < ws_n; w++)
                work_set[w] = PAGE_PORT_W'($urandom());
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if (ph == 3 && j == 20)
                    hold_requests <= hold_requests + 1;  // receiver backs up the core
                if (ph == 5 && j == PHASE_ITEMS / 2)
                    wait_all_results();
                if ($urandom_range(0, 99) < 85)
                    pg = work_set[$urandom_range(0, ws_n - 1)];
                else
                    pg = PAGE_PORT_W'($urandom());
                offer_page(pg, BY_PREDICTOR, NO_RESULT);
            end
        end

        // Back-to-back tail: one frame, mostly fresh pages, every 16th a repeat
        write_frames(4'd1);
        rush <= 1'b1;
        pg = PAGE_PORT_W'($urandom());
        for (int i = 0; i < RUSH_ITEMS; i++) begin
            if (i % 16 != 15)
                pg = pg + 1'b1;
            offer_page(pg, BY_PREDICTOR, NO_RESULT);
        end
        rush <= 1'b0;

        wait_all_results();
        repeat (FLUSH_CYCLES) @(posedge aclk);

        $display("Run: %0d requests, %0d results checked (%0d hits, %0d evictions)",
                 requests_sent, results_seen, hits_seen, evicts_seen);
        $display("Run: %0d frame-count writes incl. 0 and 15, fault count ended at %0d",
                 cfg_writes, mir_faults);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/lrupr_pkg.sv
sv/lrupr_ctrl.sv
sv/lrupr_datapath.sv
sv/lru_page_replacement_core.sv
tb/lru_page_replacement_core_tb.sv
